/* rtl/core/crcdf_pkg.sv */
// crcdf_pkg: shared types, codes and the crc byte step for the packet deframer
// no dependencies; imported by the deframer top, the assembler and the readout
package crcdf_pkg;

	localparam int HEADER_BYTES   = 3;
	localparam int OVERHEAD_BYTES = 5;

	localparam int STATUS_W   = 2;
	localparam int ID_W       = 16;
	localparam int OUT_LEN_W  = 6;
	localparam int OUT_IDX_W  = 5;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IDLE_W     = 16;

	localparam logic [15:0]       CRC_POLY      = 16'h1021;
	localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [IDLE_W-1:0] IDLE_MAX      = 16'hFFFF;

	// input command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CRC_ERR  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_REP = 2'd2;

	// what an accepted beat asks of the readout side
	typedef struct packed {
		logic                single;
		logic                burst;
		logic [STATUS_W-1:0] status;
	} crcdf_ev_t;

	// ccitt crc, msb first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		int          k;
		c = crc ^ {data, 8'h00};
		for (k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* rtl/core/crcdf_frame_ram.sv */
// crcdf_frame_ram: byte-wide frame memory, one write port, one registered read port
// depends on nothing but its parameters
module crcdf_frame_ram #(
	parameter int DEPTH  = 37,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/crcdf_assembler.sv */
// crcdf_assembler: configuration registers, fill/crc/idle tracking and frame decisions
// depends on crcdf_pkg; writes received bytes into crcdf_frame_ram
module crcdf_assembler import crcdf_pkg::*; #(
	parameter int MAX_PAYLOAD  = 32,
	parameter int BUFFER_BYTES = 37,
	parameter int ADDR_W       = $clog2(BUFFER_BYTES),
	parameter int LEN_W        = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic                  command,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output crcdf_ev_t             ev,
	output logic [ID_W-1:0]       id,
	output logic [LEN_W-1:0]      len
);

	localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
	localparam int CNT_W  = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 2;

	logic              enable_q;
	logic [IDLE_W-1:0] timeout_q;
	logic              err_rep_q;

	logic [FILL_W-1:0] fill_q, fill_d, fill_n;
	logic [15:0]       crc_q, crc_d;
	logic [IDLE_W-1:0] idle_q, idle_d;
	logic [ID_W-1:0]   id_q;
	logic [LEN_W-1:0]  len_q, len_clamp;
	logic [7:0]        prev_q;

	logic acc_byte, acc_tick, has_room, crc_cond, complete, crc_ok;
	logic [CNT_W-1:0] pos_ext;

	assign acc_byte = accept && enable_q && (command == CMD_BYTE);
	assign acc_tick = accept && enable_q && (command == CMD_TICK);
	assign has_room = fill_q < FILL_W'(BUFFER_BYTES);
	assign fill_n   = fill_q + FILL_W'(has_room);
	assign pos_ext  = CNT_W'(fill_q);
	assign crc_cond = (pos_ext < CNT_W'(HEADER_BYTES)) ||
	                  (pos_ext < CNT_W'(HEADER_BYTES) + CNT_W'(len_q));
	// length is known once the header is in, so it is safe past three bytes
	assign complete = (fill_q >= FILL_W'(HEADER_BYTES)) &&
	                  (CNT_W'(len_q) + CNT_W'(OVERHEAD_BYTES) == CNT_W'(fill_n));
	assign crc_ok   = ({prev_q, rx_byte} == crc_q);
	assign len_clamp = (rx_byte > 8'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(rx_byte);

	assign wr_en   = acc_byte && has_room;
	assign wr_addr = fill_q[ADDR_W-1:0];
	assign id      = id_q;
	assign len     = len_q;

	always_comb begin
		fill_d = fill_q;
		crc_d  = crc_q;
		idle_d = idle_q;
		ev     = '0;
		if (acc_byte) begin
			idle_d = '0;
			if (has_room) begin
				fill_d = fill_n;
				if (crc_cond) begin
					crc_d = crc_byte(crc_q, rx_byte);
				end
			end
			if (complete) begin
				fill_d = '0;
				crc_d  = '0;
				if (crc_ok) begin
					ev.status = ST_GOOD;
					if (len_q == '0) begin
						ev.single = 1'b1;
					end else begin
						ev.burst = 1'b1;
					end
				end else if (err_rep_q) begin
					ev.single = 1'b1;
					ev.status = ST_CRC_ERR;
				end
			end
		end
		if (acc_tick && (idle_q != IDLE_MAX)) begin
			idle_d = idle_q + IDLE_W'(1);
		end
		if ((acc_byte || acc_tick) && (idle_d >= timeout_q)) begin
			idle_d = '0;
			if (fill_d != '0) begin
				fill_d = '0;
				crc_d  = '0;
				if (err_rep_q) begin
					ev.single = 1'b1;
					ev.status = ST_TIMEOUT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			timeout_q <= TIMEOUT_RESET;
			err_rep_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				CFG_TIMEOUT: timeout_q <= cfg_data[IDLE_W-1:0];
				CFG_ERR_REP: err_rep_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crc_q  <= '0;
			idle_q <= '0;
		end else begin
			fill_q <= fill_d;
			crc_q  <= crc_d;
			idle_q <= idle_d;
		end
	end

	// header bytes and the previous byte kept beside the memory for the result fields and the crc check
	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_q <= rx_byte;
			if (fill_q == FILL_W'(0)) begin
				id_q[15:8] <= rx_byte;
			end
			if (fill_q == FILL_W'(1)) begin
				id_q[7:0] <= rx_byte;
			end
			if (fill_q == FILL_W'(2)) begin
				len_q <= len_clamp;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(BUFFER_BYTES))
		else $error("fill count beyond buffer");
	a_crc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (crc_q == '0))
		else $error("crc not cleared with empty frame");
	a_ev_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ev.single && ev.burst))
		else $error("single result and burst together");
	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		ev.burst |-> (len_q != '0))
		else $error("burst with zero payload length");
`endif

endmodule

/* rtl/core/crcdf_readout.sv */
// crcdf_readout: result sequencer and output register; walks the payload out of the frame memory
// depends on crcdf_pkg; reads crcdf_frame_ram
module crcdf_readout import crcdf_pkg::*; #(
	parameter int MAX_PAYLOAD  = 32,
	parameter int BUFFER_BYTES = 37,
	parameter int ADDR_W       = $clog2(BUFFER_BYTES),
	parameter int LEN_W        = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcdf_ev_t            ev,
	input  logic [ID_W-1:0]      id,
	input  logic [LEN_W-1:0]     len,
	output logic                 rd_en,
	output logic [ADDR_W-1:0]    rd_addr,
	input  logic [7:0]           rd_data,
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [ID_W-1:0]      frame_id,
	output logic [OUT_LEN_W-1:0] payload_length,
	output logic [OUT_IDX_W-1:0] byte_index,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 last
);

	localparam int SUM_W = LEN_W + 2;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic             out_valid_q, valid_d;
	logic             free, is_last, load_single, load_data;

	logic [STATUS_W-1:0]  status_q;
	logic [ID_W-1:0]      frame_id_q;
	logic [OUT_LEN_W-1:0] length_q;
	logic [OUT_IDX_W-1:0] index_q;
	logic [BYTE_W-1:0]    data_q;
	logic                 last_q;

	assign free    = !out_valid_q || !out_stall;
	assign is_last = (idx_q + LEN_W'(1)) == len;
	assign busy    = (state_q != S_IDLE);
	assign rd_addr = ADDR_W'(SUM_W'(HEADER_BYTES) + SUM_W'(idx_q));

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		valid_d     = out_valid_q && out_stall;
		load_single = 1'b0;
		load_data   = 1'b0;
		rd_en       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (ev.single) begin
					load_single = 1'b1;
					valid_d     = 1'b1;
				end else if (ev.burst) begin
					idx_d   = '0;
					state_d = S_READ;
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				// read data stays put until the next read, so waiting here is safe
				if (free) begin
					load_data = 1'b1;
					valid_d   = 1'b1;
					if (is_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + LEN_W'(1);
						state_d = S_READ;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			status_q   <= ev.status;
			frame_id_q <= (ev.status == ST_GOOD) ? id : '0;
			length_q   <= '0;
			index_q    <= '0;
			data_q     <= '0;
			last_q     <= 1'b1;
		end else if (load_data) begin
			status_q   <= ST_GOOD;
			frame_id_q <= id;
			length_q   <= OUT_LEN_W'(len);
			index_q    <= OUT_IDX_W'(idx_q);
			data_q     <= rd_data;
			last_q     <= is_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign frame_id       = frame_id_q;
	assign payload_length = length_q;
	assign byte_index     = index_q;
	assign data_byte      = data_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !(ev.single || ev.burst))
		else $error("new frame event during payload readout");
	a_read_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_LOAD))
		else $error("read not followed by load");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (idx_q < len))
		else $error("readout index past payload length");
	a_single_free: assert property (@(posedge clk) disable iff (!arst_n)
		ev.single |-> (!out_valid_q || !out_stall))
		else $error("single result with output register occupied");
`endif

endmodule

/* rtl/core/crc16_packet_deframer_top.sv */
// Packet deframer for frames of 16-bit id, length byte, payload and ccitt crc16
// (poly 0x1021, initial zero, msb first) over id, length and payload. A received byte
// or a timer tick is taken as one input beat. When a frame with a good crc completes, its
// payload bytes are read back from the frame memory, each through a registered read
// and then a load of the output register, so the input is stalled during the readout
// and during any output stall; zero-length frames and error results go out
// without a readout. There is no clearing pass after reset: frame memory entries are
// only read once written for the current frame.
// depends on crcdf_pkg, crcdf_frame_ram, crcdf_assembler and crcdf_readout
module crc16_packet_deframer_top import crcdf_pkg::*; #(
	parameter int MAX_PAYLOAD  = 32,
	parameter int BUFFER_BYTES = 37
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [ID_W-1:0]       frame_id,
	output logic [OUT_LEN_W-1:0]  payload_length,
	output logic [OUT_IDX_W-1:0]  byte_index,
	output logic [BYTE_W-1:0]     data_byte,
	output logic                  last
);

	localparam int ADDR_W = $clog2(BUFFER_BYTES);
	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

	logic              busy, accept;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]        rd_data;
	crcdf_ev_t         ev;
	logic [ID_W-1:0]   id;
	logic [LEN_W-1:0]  len;

	assign cfg_ready = 1'b1;
	// an input beat may produce a result, so it waits for a free output register and an idle readout
	assign in_stall  = busy || (out_valid && out_stall);
	assign accept    = in_valid && !in_stall;

	crcdf_frame_ram #(
		.DEPTH  (BUFFER_BYTES),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	crcdf_assembler #(
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.BUFFER_BYTES (BUFFER_BYTES),
		.ADDR_W       (ADDR_W),
		.LEN_W        (LEN_W)
	) u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.command   (command),
		.rx_byte   (rx_byte),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.ev        (ev),
		.id        (id),
		.len       (len)
	);

	crcdf_readout #(
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.BUFFER_BYTES (BUFFER_BYTES),
		.ADDR_W       (ADDR_W),
		.LEN_W        (LEN_W)
	) u_rdo (
		.clk            (clk),
		.arst_n         (arst_n),
		.ev             (ev),
		.id             (id),
		.len            (len),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.frame_id       (frame_id),
		.payload_length (payload_length),
		.byte_index     (byte_index),
		.data_byte      (data_byte),
		.last           (last)
	);

endmodule
